// File: rtl/roman_pkg.sv
// shared types, symbol codes and digit-to-symbol functions for the roman numeral converter
`default_nettype none

package roman_pkg;

  localparam int unsigned VALUE_W     = 12;
  localparam int unsigned SYMBOL_W    = 7;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned PLACES      = 4;
  localparam int unsigned MAX_VALID   = 3999;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
  localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
  localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
  localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
  localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4c;
  localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
  localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
  localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4d;

  typedef enum logic [1:0] {
    K_NORM,
    K_ZERO,
    K_OOR
  } kind_t;

  // one classified input, digits indexed by place (0 = ones)
  typedef struct packed {
    kind_t                              kind;
    logic [PLACES-1:0][DIGIT_W-1:0]     digits;
  } item_t;

  function automatic logic [SYMBOL_W-1:0] unit_sym(input logic [1:0] place);
    logic [SYMBOL_W-1:0] s;
    case (place)
      2'd0:    s = SYM_I;
      2'd1:    s = SYM_X;
      2'd2:    s = SYM_C;
      default: s = SYM_M;
    endcase
    return s;
  endfunction

  function automatic logic [SYMBOL_W-1:0] five_sym(input logic [1:0] place);
    logic [SYMBOL_W-1:0] s;
    case (place)
      2'd0:    s = SYM_V;
      2'd1:    s = SYM_L;
      2'd2:    s = SYM_D;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [SYMBOL_W-1:0] ten_sym(input logic [1:0] place);
    logic [SYMBOL_W-1:0] s;
    case (place)
      2'd0:    s = SYM_X;
      2'd1:    s = SYM_C;
      2'd2:    s = SYM_M;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

  // number of symbols one nonzero digit expands to
  function automatic logic [2:0] sym_count(input logic [DIGIT_W-1:0] digit);
    logic [2:0] n;
    case (digit) inside
      4'd4, 4'd9:    n = 3'd2;
      [4'd5:4'd8]:   n = 3'(digit - 4'd4);
      [4'd1:4'd3]:   n = digit[2:0];
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  // symbol at position idx of the expansion of digit at place
  function automatic logic [SYMBOL_W-1:0] sym_at(input logic [DIGIT_W-1:0] digit,
                                                 input logic [1:0] place,
                                                 input logic [2:0] idx);
    logic [SYMBOL_W-1:0] s;
    case (digit) inside
      4'd9:        s = (idx == 3'd0) ? unit_sym(place) : ten_sym(place);
      4'd4:        s = (idx == 3'd0) ? unit_sym(place) : five_sym(place);
      [4'd5:4'd8]: s = (idx == 3'd0) ? five_sym(place) : unit_sym(place);
      default:     s = unit_sym(place);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/roman_front.sv
// front end: accepts a value, classifies it and splits it into decimal digits
`default_nettype none

module roman_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire logic [roman_pkg::VALUE_W-1:0]  in_value,
  output logic                                in_full,
  output logic                                q_push,
  output roman_pkg::item_t                    q_item,
  input  wire logic                           q_full
);
  import roman_pkg::*;

  localparam int unsigned UNIT_THOUSANDS = 1000;
  localparam int unsigned UNIT_HUNDREDS  = 100;
  localparam int unsigned UNIT_TENS      = 10;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPLIT,
    F_PUSH
  } fstate_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rem;
  } split_t;

  // one decimal digit by comparing against the nine multiples of the unit
  function automatic split_t split_digit(input logic [VALUE_W-1:0] rem,
                                         input int unsigned unit);
    split_t res;
    res.digit = '0;
    res.rem   = rem;
    for (int unsigned k = 1; k <= 9; k++) begin
      if ({2'b00, rem} >= 14'(k * unit)) begin
        res.digit = 4'(k);
        res.rem   = rem - VALUE_W'(k * unit);
      end
    end
    return res;
  endfunction

  fstate_t             state_r, state_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [VALUE_W-1:0]  rem_r, rem_nxt;
  item_t               item_r, item_nxt;
  split_t              sp_th, sp_hu, sp_te;

  assign sp_th = split_digit(rem_r, UNIT_THOUSANDS);
  assign sp_hu = split_digit(rem_r, UNIT_HUNDREDS);
  assign sp_te = split_digit(rem_r, UNIT_TENS);

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_item  = item_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    item_nxt  = item_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          item_nxt.digits = '0;
          rem_nxt         = in_value;
          step_nxt        = 2'd0;
          if (in_value > VALUE_W'(MAX_VALID)) begin
            item_nxt.kind = K_OOR;
            state_nxt     = F_PUSH;
          end else if (in_value == '0) begin
            item_nxt.kind = K_ZERO;
            state_nxt     = F_PUSH;
          end else begin
            item_nxt.kind = K_NORM;
            state_nxt     = F_SPLIT;
          end
        end
      end
      F_SPLIT: begin
        case (step_r)
          2'd0: begin
            item_nxt.digits[3] = sp_th.digit;
            rem_nxt            = sp_th.rem;
            step_nxt           = 2'd1;
          end
          2'd1: begin
            item_nxt.digits[2] = sp_hu.digit;
            rem_nxt            = sp_hu.rem;
            step_nxt           = 2'd2;
          end
          2'd2: begin
            item_nxt.digits[1] = sp_te.digit;
            item_nxt.digits[0] = sp_te.rem[DIGIT_W-1:0];
            state_nxt          = F_PUSH;
          end
          default: begin
            state_nxt = F_PUSH;
          end
        endcase
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    rem_r  <= rem_nxt;
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/roman_queue.sv
// two-entry queue of classified items between front and back
`default_nettype none

module roman_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire roman_pkg::item_t  push_item,
  output logic                   full,
  input  wire logic              pop,
  output roman_pkg::item_t       pop_item,
  output logic                   empty
);
  import roman_pkg::*;

  item_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]      count_r;
  logic                 do_push, do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

// File: rtl/roman_back.sv
// back end: walks an item's digits; a symbol or empty result per transfer
`default_nettype none

module roman_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire roman_pkg::item_t                q_item,
  output logic                                 q_pop,
  input  wire logic                            out_pop,
  output logic                                 out_empty,
  output logic [roman_pkg::SYMBOL_W-1:0]       out_symbol,
  output logic                                 out_has_symbol,
  output logic                                 out_out_of_range,
  output logic                                 out_last
);
  import roman_pkg::*;

  logic                  active_r, active_nxt;
  item_t                 item_r, item_nxt;
  logic [1:0]            place_r, place_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic                  oval_r, oval_nxt;
  logic [SYMBOL_W-1:0]   osym_r, osym_nxt;
  logic                  ohas_r, ohas_nxt;
  logic                  ooor_r, ooor_nxt;
  logic                  olast_r, olast_nxt;

  logic [DIGIT_W-1:0]    cur_digit;
  logic [2:0]            cur_cnt;
  logic                  lower_nz;
  logic                  slot_free;

  assign cur_digit = item_r.digits[place_r];
  assign cur_cnt   = sym_count(cur_digit);
  assign slot_free = !oval_r || out_pop;

  // any nonzero digit below the current place means more symbols follow
  always_comb begin
    lower_nz = 1'b0;
    for (int i = 0; i < PLACES; i++) begin
      if ((2'(i) < place_r) && (item_r.digits[i] != '0)) lower_nz = 1'b1;
    end
  end

  always_comb begin
    active_nxt = active_r;
    item_nxt   = item_r;
    place_nxt  = place_r;
    idx_nxt    = idx_r;
    oval_nxt   = oval_r;
    osym_nxt   = osym_r;
    ohas_nxt   = ohas_r;
    ooor_nxt   = ooor_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;

    if (oval_r && out_pop) oval_nxt = 1'b0;

    if (!active_r) begin
      if (!q_empty) begin
        q_pop      = 1'b1;
        item_nxt   = q_item;
        place_nxt  = 2'd3;
        idx_nxt    = 3'd0;
        active_nxt = 1'b1;
      end
    end else if (item_r.kind != K_NORM) begin
      if (slot_free) begin
        oval_nxt   = 1'b1;
        osym_nxt   = SYM_NONE;
        ohas_nxt   = 1'b0;
        ooor_nxt   = (item_r.kind == K_OOR);
        olast_nxt  = 1'b1;
        active_nxt = 1'b0;
      end
    end else if (cur_digit == '0) begin
      place_nxt = place_r - 2'd1;
    end else if (slot_free) begin
      oval_nxt  = 1'b1;
      osym_nxt  = sym_at(cur_digit, place_r, idx_r);
      ohas_nxt  = 1'b1;
      ooor_nxt  = 1'b0;
      olast_nxt = 1'b0;
      if (idx_r == cur_cnt - 3'd1) begin
        idx_nxt   = 3'd0;
        place_nxt = place_r - 2'd1;
        if (!lower_nz) begin
          olast_nxt  = 1'b1;
          active_nxt = 1'b0;
        end
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      oval_r   <= oval_nxt;
    end
    item_r  <= item_nxt;
    place_r <= place_nxt;
    idx_r   <= idx_nxt;
    osym_r  <= osym_nxt;
    ohas_r  <= ohas_nxt;
    ooor_r  <= ooor_nxt;
    olast_r <= olast_nxt;
  end

  assign out_empty        = !oval_r;
  assign out_symbol       = osym_r;
  assign out_has_symbol   = ohas_r;
  assign out_out_of_range = ooor_r;
  assign out_last         = olast_r;

endmodule

`default_nettype wire

// File: rtl/integer_to_roman_numeral.sv
// front: accept and classify, split the digits (thousands, hundreds, then tens and ones), hand off to the queue
// back: load an item, then skip each zero digit and emit each symbol in turn
// the front takes a new value once it has handed the last one to the queue, while the back may still be emitting
// zero and out-of-range values skip the digit split and give a single result with no symbol
// reset: synchronous active-low rst_n empties the queue and the result register
`default_nettype none

module integer_to_roman_numeral (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [roman_pkg::VALUE_W-1:0]  in_value,
  input  wire logic                           out_pop,
  output logic                                out_empty,
  output logic [roman_pkg::SYMBOL_W-1:0]      out_symbol,
  output logic                                out_has_symbol,
  output logic                                out_out_of_range,
  output logic                                out_last
);
  import roman_pkg::*;

  logic   fq_push, fq_full;
  item_t  fq_item;
  logic   bq_pop, bq_empty;
  item_t  bq_item;

  roman_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_push   (fq_push),
    .q_item   (fq_item),
    .q_full   (fq_full)
  );

  roman_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (bq_pop),
    .pop_item  (bq_item),
    .empty     (bq_empty)
  );

  roman_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (bq_empty),
    .q_item           (bq_item),
    .q_pop            (bq_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_symbol       (out_symbol),
    .out_has_symbol   (out_has_symbol),
    .out_out_of_range (out_out_of_range),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/roman_checker.sv
// port-level assertions for the roman numeral converter, bound to the top level
`default_nettype none

module roman_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_full,
  input wire logic                           out_pop,
  input wire logic                           out_empty,
  input wire logic [roman_pkg::SYMBOL_W-1:0] out_symbol,
  input wire logic                           out_has_symbol,
  input wire logic                           out_out_of_range,
  input wire logic                           out_last
);
  import roman_pkg::*;

  // reset leaves nothing to deliver and the input side open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("results pending or input blocked after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_symbol) && $stable(out_last)))
    else $error("waiting result changed before transfer");

  // an out-of-range result is a lone, empty, final result
  a_oor_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_out_of_range) |-> (out_last && !out_has_symbol))
    else $error("out-of-range result malformed");

  // a symbol result carries one of the seven numeral letters
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_has_symbol) |->
      (out_symbol == SYM_I || out_symbol == SYM_V || out_symbol == SYM_X ||
       out_symbol == SYM_L || out_symbol == SYM_C || out_symbol == SYM_D ||
       out_symbol == SYM_M))
    else $error("symbol is not a roman numeral letter");

  // a reject or zero result comes only after the previous run ended
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=> (!out_empty |-> out_has_symbol))
    else $error("empty result inside a run of symbols");

endmodule

bind integer_to_roman_numeral roman_checker u_roman_checker (.*);

`default_nettype wire
